// ===== hw/rtl/tea_pkg.sv =====
// tea_pkg: shared types, constants and the round mixing function
// for the tea block cipher pipeline; no dependencies

package tea_pkg;

   localparam int unsigned WORD_W         = 32;
   localparam int unsigned ROUNDS_DEFAULT = 16;
   localparam int unsigned CSR_ADDR_W     = 4;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam logic [WORD_W-1:0] DELTA    = 32'h9e37_79b9;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      REG_KEY0 = 2'd0,
      REG_KEY1 = 2'd1,
      REG_KEY2 = 2'd2,
      REG_KEY3 = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   typedef struct packed {
      word_type k3;
      word_type k2;
      word_type k1;
      word_type k0;
   } key_type;

   typedef struct packed {
      op_type   op;
      word_type right;
      word_type left;
   } beat_type;

   // round sum constant, delta times n modulo 2^32
   function automatic word_type delta_mult(input int unsigned n);
      logic [63:0] prod;
      prod = 64'(DELTA) * 64'(n);
      return prod[WORD_W-1:0];
   endfunction

   function automatic word_type tea_mix(input word_type v, input word_type sum,
                                        input word_type ka, input word_type kb);
      word_type a;
      word_type b;
      word_type c;
      a = (v << 4) + ka;
      b = v + sum;
      c = (v >> 5) + kb;
      return a ^ b ^ c;
   endfunction

endpackage

// ===== hw/rtl/tea_csr.sv =====
// tea_csr: key registers behind the apb-style configuration port
// depends on tea_pkg

module tea_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tea_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tea_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tea_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output tea_pkg::key_type                   key
);

   tea_pkg::key_type      key_ff;
   tea_pkg::key_type      key_in;
   tea_pkg::reg_index_type reg_idx;
   logic                  wr_en;

   assign reg_idx    = tea_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign key        = key_ff;

   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tea_pkg::REG_KEY0: key_in.k0 = csr_pwdata;
            tea_pkg::REG_KEY1: key_in.k1 = csr_pwdata;
            tea_pkg::REG_KEY2: key_in.k2 = csr_pwdata;
            tea_pkg::REG_KEY3: key_in.k3 = csr_pwdata;
            default:           key_in = key_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tea_pkg::REG_KEY0: csr_prdata = key_ff.k0;
         tea_pkg::REG_KEY1: csr_prdata = key_ff.k1;
         tea_pkg::REG_KEY2: csr_prdata = key_ff.k2;
         tea_pkg::REG_KEY3: csr_prdata = key_ff.k3;
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

endmodule

// ===== hw/rtl/tea_half_round.sv =====
// tea_half_round: one registered half-round of the tea feistel network,
// encrypt or decrypt per beat, with its own valid bit; depends on tea_pkg

module tea_half_round #(
   parameter int unsigned ROUNDS    = tea_pkg::ROUNDS_DEFAULT,
   parameter int unsigned STAGE_IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tea_pkg::beat_type in_beat,
   output logic              in_ready,
   input  tea_pkg::key_type  key,
   output logic              out_valid,
   output tea_pkg::beat_type out_beat,
   input  logic              out_ready
);

   localparam int unsigned ROUND_IDX = STAGE_IDX / 2;
   localparam logic        SECOND    = 1'((STAGE_IDX % 2));
   localparam tea_pkg::word_type SUM_ENC = tea_pkg::delta_mult(ROUND_IDX + 1);
   localparam tea_pkg::word_type SUM_DEC = tea_pkg::delta_mult(ROUNDS - ROUND_IDX);

   logic              valid_ff;
   logic              valid_in;
   tea_pkg::beat_type beat_ff;
   tea_pkg::beat_type beat_in;
   logic              load;
   logic              upd_left;
   logic              is_dec;
   tea_pkg::word_type src;
   tea_pkg::word_type dst;
   tea_pkg::word_type sum;
   tea_pkg::word_type ka;
   tea_pkg::word_type kb;
   tea_pkg::word_type mixed;
   tea_pkg::word_type res;

   assign in_ready  = ~valid_ff | out_ready;
   assign load      = in_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   // enc first half and dec second half update the left word
   assign is_dec   = (in_beat.op == tea_pkg::OP_DECRYPT);
   assign upd_left = (is_dec == SECOND);
   assign src      = upd_left ? in_beat.right : in_beat.left;
   assign dst      = upd_left ? in_beat.left : in_beat.right;
   assign ka       = upd_left ? key.k0 : key.k2;
   assign kb       = upd_left ? key.k1 : key.k3;
   assign sum      = is_dec ? SUM_DEC : SUM_ENC;
   assign mixed    = tea_pkg::tea_mix(src, sum, ka, kb);
   assign res      = is_dec ? (dst - mixed) : (dst + mixed);

   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in    = in_valid;
         beat_in     = in_beat;
         if (upd_left) begin
            beat_in.left = res;
         end else begin
            beat_in.right = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

endmodule

// ===== hw/rtl/tea_block_cipher_16_round.sv =====
// tea_block_cipher_16_round: one register stage per half-round; throughput one
// block per cycle while rsp_tready holds
// stages move independently, so empty stages fill even while the output stalls
// reset (synchronous, active high) empties the pipeline and clears the key to zero
// depends on tea_pkg, tea_csr and tea_half_round

module tea_block_cipher_16_round #(
   parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [63:0]                    req_tdata,   // block_right in [63:32], block_left in [31:0]
   input  logic                           req_tuser,   // opcode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,   // out_right in [63:32], out_left in [31:0]
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tea_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tea_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tea_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int unsigned STAGES = 2 * ROUNDS;

   tea_pkg::key_type  key;
   logic              valid_chain [STAGES+1];
   logic              ready_chain [STAGES+1];
   tea_pkg::beat_type beat_chain  [STAGES+1];
   logic [STAGES-1:0] stage_occ;

   tea_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key         (key)
   );

   assign valid_chain[0]       = req_tvalid;
   assign beat_chain[0].op     = tea_pkg::op_type'(req_tuser);
   assign beat_chain[0].left   = req_tdata[31:0];
   assign beat_chain[0].right  = req_tdata[63:32];
   assign req_tready           = ready_chain[0];
   assign ready_chain[STAGES]  = rsp_tready;
   assign rsp_tvalid           = valid_chain[STAGES];
   assign rsp_tdata            = {beat_chain[STAGES].right, beat_chain[STAGES].left};

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      tea_half_round #(
         .ROUNDS    (ROUNDS),
         .STAGE_IDX (s)
      ) u_half_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[s]),
         .in_beat   (beat_chain[s]),
         .in_ready  (ready_chain[s]),
         .key       (key),
         .out_valid (valid_chain[s+1]),
         .out_beat  (beat_chain[s+1]),
         .out_ready (ready_chain[s+1])
      );
      assign stage_occ[s] = valid_chain[s+1];
   end

`ifndef NO_ASSERTIONS
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (stage_occ == '0))
      else $error("pipeline not empty after reset");

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && (&stage_occ)) |-> !req_tready)
      else $error("input accepted while pipeline full and stalled");

   a_no_beat_lost: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && rsp_tready) |=> ($countones(stage_occ) >= $past($countones(stage_occ))))
      else $error("beat dropped inside pipeline");

   a_no_beat_invented: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(stage_occ) <= ($past($countones(stage_occ)) + 1)))
      else $error("more than one beat entered in a cycle");
`endif

endmodule

// ===== bench/tea_checker.sv =====
// tea_checker: watches the block, key and result channels of the tea cipher,
// predicts every result block from its own copy of the key and flags mismatches
// depends on tea_pkg

module tea_checker #(
   parameter int unsigned ROUNDS = tea_pkg::ROUNDS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [63:0]                    req_tdata,   // block_right in [63:32], block_left in [31:0]
   input  logic                           req_tuser,   // opcode
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [63:0]                    rsp_tdata,   // out_right in [63:32], out_left in [31:0]
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [tea_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tea_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             error_count,
   output int                             blocks_in_flight
);
   import tea_pkg::*;

   typedef struct packed {
      word_type left;
      word_type right;
   } block_pair_type;

   key_type        cipher_key;
   block_pair_type expected_blocks[$];
   int             fail_total = 0;

   assign error_count      = fail_total;
   assign blocks_in_flight = expected_blocks.size();

   function automatic word_type round_mix(input word_type v, input word_type sum,
                                          input word_type ka, input word_type kb);
      return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
   endfunction

   function automatic block_pair_type tea_transform(input op_type op, input word_type left,
                                                    input word_type right, input key_type k);
      word_type       l;
      word_type       r;
      word_type       sum;
      block_pair_type res;
      l = left;
      r = right;
      if (op == OP_ENCRYPT) begin
         sum = '0;
         for (int i = 0; i < ROUNDS; i++) begin
            sum += DELTA;
            l += round_mix(r, sum, k.k0, k.k1);
            r += round_mix(l, sum, k.k2, k.k3);
         end
      end else begin
         // start sum wraps modulo 2^32
         sum = DELTA * word_type'(ROUNDS);
         for (int i = 0; i < ROUNDS; i++) begin
            r -= round_mix(l, sum, k.k2, k.k3);
            l -= round_mix(r, sum, k.k0, k.k1);
            sum -= DELTA;
         end
      end
      res.left  = l;
      res.right = r;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_total < 40)
         $display("tea check: %s got %h expected %h", what, got, want);
      fail_total++;
   endtask

   always @(posedge clock) begin
      block_pair_type want;
      if (reset) begin
         cipher_key = '0;
         expected_blocks.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_blocks.push_back(tea_transform(op_type'(req_tuser), req_tdata[31:0],
                                                    req_tdata[63:32], cipher_key));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_KEY0: cipher_key.k0 = csr_pwdata;
               REG_KEY1: cipher_key.k1 = csr_pwdata;
               REG_KEY2: cipher_key.k2 = csr_pwdata;
               REG_KEY3: cipher_key.k3 = csr_pwdata;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch("unexpected result beat, left", rsp_tdata[31:0], '0);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_tdata[31:0] !== want.left)
                  report_mismatch("out_left", rsp_tdata[31:0], want.left);
               if (rsp_tdata[63:32] !== want.right)
                  report_mismatch("out_right", rsp_tdata[63:32], want.right);
            end
         end
      end
   end

endmodule

// ===== bench/tb_tea_block_cipher_16_round.sv =====
// tb_tea_block_cipher_16_round: drives key writes and cipher blocks into the tea
// pipeline with random idling on both sides and reports the verdict
// depends on tea_pkg, tea_block_cipher_16_round and tea_checker

module tb_tea_block_cipher_16_round;
   import tea_pkg::*;

   localparam int unsigned ROUNDS = ROUNDS_DEFAULT;
   localparam int          LIMIT  = 400000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [63:0]           rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          error_count;
   int          blocks_in_flight;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int          cycle_count    = 0;

   tea_block_cipher_16_round #(.ROUNDS(ROUNDS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tea_checker #(.ROUNDS(ROUNDS)) block_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .error_count      (error_count),
      .blocks_in_flight (blocks_in_flight)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic word_type pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // all tasks start and end right after a rising edge
   task automatic send_block(input op_type op, input word_type left, input word_type right);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom};
         req_tuser  <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      req_tuser  <= op;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (blocks_in_flight != 0);
      @(posedge clock);
   endtask

   task automatic write_key_word(input reg_index_type idx, input word_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (!csr_pready);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_key(input word_type k0, input word_type k1,
                           input word_type k2, input word_type k3);
      write_key_word(REG_KEY0, k0);
      write_key_word(REG_KEY1, k1);
      write_key_word(REG_KEY2, k2);
      write_key_word(REG_KEY3, k3);
   endtask

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tea_block_cipher_16_round: mismatch");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // key still at its reset value of zero
      send_block(OP_ENCRYPT, '0, '0);
      send_block(OP_ENCRYPT, '1, '1);
      send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
      send_block(OP_DECRYPT, '0, '0);
      send_block(OP_DECRYPT, '1, '1);
      send_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);
      wait_drained();
      load_key('1, '1, '1, '1);
      send_block(OP_ENCRYPT, '0, '0);
      send_block(OP_ENCRYPT, '1, '1);
      send_block(OP_DECRYPT, '0, '0);
      send_block(OP_DECRYPT, '1, '1);
      wait_drained();
      load_key(32'h8000_0000, 32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa);
      send_block(OP_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555);
      send_block(OP_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555);
      send_block(OP_ENCRYPT, 32'hffff_fffe, 32'h7fff_ffff);
      send_block(OP_DECRYPT, 32'h7fff_ffff, 32'hffff_fffe);

      for (int seg = 0; seg < 9; seg++) begin
         wait_drained();
         case (seg % 4)
            0: load_key('1, '1, '1, '1);
            1: load_key('0, '0, '0, '0);
            2: load_key($urandom, $urandom, $urandom, $urandom);
            default: load_key(pick_word(), pick_word(), pick_word(), pick_word());
         endcase
         case (seg / 3)
            0: begin
               send_idle_pct  = 16;
               recv_stall_pct = 82;
            end
            1: begin
               send_idle_pct  = 82;
               recv_stall_pct = 16;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < 150; n++) begin
            if (n == 75)
               wait_drained();
            send_block(op_type'($urandom_range(1)), pick_word(), pick_word());
         end
      end

      wait_drained();
      repeat (2 * ROUNDS + 8) @(posedge clock);
      if (error_count == 0)
         $display("tea_block_cipher_16_round: match");
      else
         $display("tea_block_cipher_16_round: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/tea_pkg.sv
hw/rtl/tea_csr.sv
hw/rtl/tea_half_round.sv
hw/rtl/tea_block_cipher_16_round.sv
bench/tea_checker.sv
bench/tb_tea_block_cipher_16_round.sv
